FILE: design/uesf_pkg.sv
// ----------------------------------------------------------------------------
// uesf_pkg: shared types and constants for the URL endpoint filter
// Section encoding, verdict codes, scheme lookup and the tracker status bundle.
// ----------------------------------------------------------------------------
package uesf_pkg;

    typedef enum logic [5:0] {
        SEC_SCHEME = 6'b000001,
        SEC_SLASH1 = 6'b000010,
        SEC_SLASH2 = 6'b000100,
        SEC_HOST   = 6'b001000,
        SEC_TAIL   = 6'b010000,
        SEC_BAD    = 6'b100000
    } section_t;

    typedef logic [2:0] verdict_t;

    localparam verdict_t VERDICT_ALLOWED   = 3'd0;
    localparam verdict_t VERDICT_SCHEME    = 3'd1;
    localparam verdict_t VERDICT_CONTROL   = 3'd2;
    localparam verdict_t VERDICT_METADATA  = 3'd3;
    localparam verdict_t VERDICT_LINKLOCAL = 3'd4;
    localparam verdict_t VERDICT_MALFORMED = 3'd5;

    localparam logic [2:0] SCHEME_LEN      = 3'd5;
    localparam logic [2:0] SCHEME_HTTP     = 3'd4;
    localparam logic [2:0] SCHEME_MISMATCH = 3'd6;

    localparam logic [7:0] OCT_169 = 8'd169;
    localparam logic [7:0] OCT_254 = 8'd254;
    localparam logic [7:0] OCT_100 = 8'd100;
    localparam logic [7:0] OCT_200 = 8'd200;
    localparam logic [11:0] OCT_MAX = 12'd255;

    typedef struct packed {
        section_t   section;
        logic       saw_control;
        logic       saw_any_char;
        logic       hostport_nonempty;
        logic       host_nonempty;
        logic [1:0] octet_index;
        logic [1:0] digit_count;
        logic [7:0] octet_value;
        logic       ipv4_invalid;
        logic [7:0] octet0;
        logic [7:0] octet1;
        logic [7:0] octet2;
    } tracker_status_t;

    // expected lowercase letter of "https" at a given match position
    function automatic logic [7:0] scheme_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = "h";
            3'd1:    ch = "t";
            3'd2:    ch = "t";
            3'd3:    ch = "p";
            3'd4:    ch = "s";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

FILE: design/uesf_tracker.sv
// ----------------------------------------------------------------------------
// uesf_tracker: per-character URL parse state
// Walks scheme, slashes and host; accumulates dotted IPv4 octets.
// ----------------------------------------------------------------------------
module uesf_tracker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      char_en,
    input  logic                      end_en,
    input  logic [7:0]                char_code,
    output uesf_pkg::tracker_status_t status
);
    import uesf_pkg::*;

    section_t   section_reg, section_next;
    logic [2:0] progress_reg, progress_next;
    logic       saw_control_reg, saw_control_next;
    logic       saw_any_reg, saw_any_next;
    logic       hostport_reg, hostport_next;
    logic       host_reg, host_next;
    logic [1:0] oct_idx_reg, oct_idx_next;
    logic [1:0] digits_reg, digits_next;
    logic [7:0] oct_val_reg, oct_val_next;
    logic       invalid_reg, invalid_next;
    logic [7:0] store_reg [3];
    logic       store_we;

    logic [7:0]  lower;
    logic [11:0] acc;
    logic        is_digit;

    assign is_digit = (char_code >= "0") && (char_code <= "9");
    assign lower    = ((char_code >= "A") && (char_code <= "Z")) ? char_code + 8'd32
                                                                  : char_code;
    // octet_value * 10 + digit
    assign acc = {1'b0, oct_val_reg, 3'b000} + {3'b000, oct_val_reg, 1'b0}
               + {8'h00, char_code[3:0]};

    always_comb
    begin
        section_next      = section_reg;
        progress_next     = progress_reg;
        saw_control_next  = saw_control_reg;
        saw_any_next      = saw_any_reg;
        hostport_next     = hostport_reg;
        host_next         = host_reg;
        oct_idx_next      = oct_idx_reg;
        digits_next       = digits_reg;
        oct_val_next      = oct_val_reg;
        invalid_next      = invalid_reg;
        store_we          = 1'b0;
        if (end_en)
        begin
            section_next     = SEC_SCHEME;
            progress_next    = 3'd0;
            saw_control_next = 1'b0;
            saw_any_next     = 1'b0;
            hostport_next    = 1'b0;
            host_next        = 1'b0;
            oct_idx_next     = 2'd0;
            digits_next      = 2'd0;
            oct_val_next     = 8'd0;
            invalid_next     = 1'b0;
        end
        else if (char_en)
        begin
            saw_any_next = 1'b1;
            if (char_code == 8'd13 || char_code == 8'd10 || char_code == 8'd0)
                saw_control_next = 1'b1;
            case (section_reg)
                SEC_SCHEME:
                begin
                    if (char_code == ":")
                        section_next = (progress_reg == SCHEME_HTTP ||
                                        progress_reg == SCHEME_LEN) ? SEC_SLASH1 : SEC_BAD;
                    else if (progress_reg < SCHEME_LEN && lower == scheme_char(progress_reg))
                        progress_next = progress_reg + 3'd1;
                    else
                        progress_next = SCHEME_MISMATCH;
                end
                SEC_SLASH1: section_next = (char_code == "/") ? SEC_SLASH2 : SEC_BAD;
                SEC_SLASH2: section_next = (char_code == "/") ? SEC_HOST : SEC_BAD;
                SEC_HOST:
                begin
                    if (char_code == "/" || char_code == "?" || char_code == "#")
                        section_next = SEC_TAIL;
                    else if (char_code == ":")
                    begin
                        hostport_next = 1'b1;
                        section_next  = SEC_TAIL;
                    end
                    else
                    begin
                        hostport_next = 1'b1;
                        host_next     = 1'b1;
                        if (is_digit)
                        begin
                            if (digits_reg == 2'd3 || acc > OCT_MAX)
                                invalid_next = 1'b1;
                            else
                            begin
                                oct_val_next = acc[7:0];
                                digits_next  = digits_reg + 2'd1;
                            end
                        end
                        else if (char_code == ".")
                        begin
                            if (digits_reg == 2'd0 || oct_idx_reg == 2'd3)
                                invalid_next = 1'b1;
                            else
                            begin
                                store_we     = 1'b1;
                                oct_idx_next = oct_idx_reg + 2'd1;
                                digits_next  = 2'd0;
                                oct_val_next = 8'd0;
                            end
                        end
                        else
                            invalid_next = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            section_reg     <= SEC_SCHEME;
            progress_reg    <= 3'd0;
            saw_control_reg <= 1'b0;
            saw_any_reg     <= 1'b0;
            hostport_reg    <= 1'b0;
            host_reg        <= 1'b0;
            oct_idx_reg     <= 2'd0;
            digits_reg      <= 2'd0;
            oct_val_reg     <= 8'd0;
            invalid_reg     <= 1'b0;
        end
        else
        begin
            section_reg     <= section_next;
            progress_reg    <= progress_next;
            saw_control_reg <= saw_control_next;
            saw_any_reg     <= saw_any_next;
            hostport_reg    <= hostport_next;
            host_reg        <= host_next;
            oct_idx_reg     <= oct_idx_next;
            digits_reg      <= digits_next;
            oct_val_reg     <= oct_val_next;
            invalid_reg     <= invalid_next;
        end
    end

    // octets are only read once all three are written in the current URL
    always_ff @(posedge clk)
    begin
        if (store_we)
            store_reg[oct_idx_reg] <= oct_val_reg;
    end

    assign status.section           = section_reg;
    assign status.saw_control       = saw_control_reg;
    assign status.saw_any_char      = saw_any_reg;
    assign status.hostport_nonempty = hostport_reg;
    assign status.host_nonempty     = host_reg;
    assign status.octet_index       = oct_idx_reg;
    assign status.digit_count       = digits_reg;
    assign status.octet_value       = oct_val_reg;
    assign status.ipv4_invalid      = invalid_reg;
    assign status.octet0            = store_reg[0];
    assign status.octet1            = store_reg[1];
    assign status.octet2            = store_reg[2];

endmodule

FILE: design/uesf_judge.sv
// ----------------------------------------------------------------------------
// uesf_judge: verdict decision and result register
// Ranks the checks and holds the verdict until the receiver takes it.
// ----------------------------------------------------------------------------
module uesf_judge (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      end_en,
    input  uesf_pkg::tracker_status_t status,
    input  logic                      out_stall,
    output logic                      out_valid,
    output uesf_pkg::verdict_t        verdict
);
    import uesf_pkg::*;

    verdict_t decision;
    verdict_t verdict_reg;
    logic     valid_reg, valid_next;
    logic     is_ipv4;
    logic     pre_ok;

    assign is_ipv4 = !status.ipv4_invalid && status.octet_index == 2'd3
                     && status.digit_count != 2'd0;
    assign pre_ok  = status.octet0 == OCT_169 && status.octet1 == OCT_254;

    always_comb
    begin
        if (!status.saw_any_char)
            decision = VERDICT_ALLOWED;
        else if (status.saw_control)
            decision = VERDICT_CONTROL;
        else if (status.section != SEC_HOST && status.section != SEC_TAIL)
            decision = VERDICT_SCHEME;
        else if (!status.hostport_nonempty || !status.host_nonempty)
            decision = VERDICT_MALFORMED;
        else if (is_ipv4 && pre_ok && status.octet2 == OCT_169
                 && status.octet_value == OCT_254)
            decision = VERDICT_METADATA;
        else if (is_ipv4 && status.octet0 == OCT_100 && status.octet1 == OCT_100
                 && status.octet2 == OCT_100 && status.octet_value == OCT_200)
            decision = VERDICT_METADATA;
        else if (is_ipv4 && pre_ok)
            decision = VERDICT_LINKLOCAL;
        else
            decision = VERDICT_ALLOWED;
    end

    assign valid_next = end_en | (valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (end_en)
            verdict_reg <= decision;
    end

    assign out_valid = valid_reg;
    assign verdict   = verdict_reg;

endmodule

FILE: design/url_endpoint_ssrf_filter.sv
// ----------------------------------------------------------------------------
// url_endpoint_ssrf_filter: SSRF screening of a streamed URL
// Parses scheme and host on the fly and gives one verdict per URL.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall, func, char_code): one transfer per URL
//   byte with func = 0, then one transfer with func = 1 to close the URL.
//   Output channel (out_valid / out_stall, verdict): one transfer per closed
//   URL; character transfers produce nothing.
// Latency: the verdict is valid the cycle after the end marker transfer.
// Throughput: one input transfer per cycle while in_stall is low; the tracker
//   updates its parse state on every accepted transfer.
// Stall: the result register holds its verdict while out_stall is high; the
//   input then stalls only while a verdict is waiting and not being taken,
//   and accepts again in the same cycle the waiting verdict leaves.
// Reset: rst_n clears the parse state and the result valid flag at once; the
//   parse state also clears after every end marker.
// Verdicts: 0 allowed, 1 bad scheme, 2 control char, 3 metadata address,
//   4 link local, 5 malformed.
// ----------------------------------------------------------------------------
module url_endpoint_ssrf_filter (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 func,
    input  logic [7:0]           char_code,
    output logic                 out_valid,
    input  logic                 out_stall,
    output uesf_pkg::verdict_t   verdict
);
    import uesf_pkg::*;

    tracker_status_t status;
    logic            accept;
    logic            char_en;
    logic            end_en;

    // hold off input only while a verdict sits unclaimed in the result register
    assign in_stall = out_valid & out_stall;
    assign accept   = in_valid & ~in_stall;
    assign char_en  = accept & ~func;
    assign end_en   = accept & func;

    uesf_tracker u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_en   (char_en),
        .end_en    (end_en),
        .char_code (char_code),
        .status    (status)
    );

    // verdict is taken from the state before the end marker clears it
    uesf_judge u_judge (
        .clk       (clk),
        .rst_n     (rst_n),
        .end_en    (end_en),
        .status    (status),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .verdict   (verdict)
    );

endmodule
